// ===== rtl/sida_pkg.sv =====
// ----------------------------------------------------------------------------
// sida_pkg: shared types and constants
// Transaction structs, sequencer states and ASCII constants for the
// signed integer to padded decimal text converter.
// ----------------------------------------------------------------------------
package sida_pkg;

  // conversion limits
  localparam int MaxWidth   = 32;
  localparam int MagWidth   = 32;
  localparam int BcdDigits  = 10;
  localparam int StepBits   = $clog2(MagWidth);

  // ascii codes
  localparam logic [7:0] AsciiZero  = 8'd48;
  localparam logic [7:0] AsciiMinus = 8'd45;
  localparam logic [7:0] PadReset   = 8'd48;

  // input transaction
  typedef struct packed {
    logic signed [31:0] value;
    logic        [5:0]  min_width;
  } cmd_t;

  // output transaction, one character
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } res_t;

  // decimal digits, least significant at index 0
  typedef logic [BcdDigits-1:0][3:0] bcd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_COUNT,
    ST_EMIT
  } state_t;

endpackage

// ===== rtl/signed_int_to_decimal_ascii_padded_core.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_padded_core: signed integer to padded ascii
// Converts a signed 32-bit value to decimal text with a minimum field width.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. The value is
// converted to decimal by a shift-and-add-3 unit that handles one bit per
// cycle, then the text goes out one character per cycle, most significant
// first: pad characters, an optional minus sign, then the digits. Each
// character sits on result for exactly one cycle, marked by strobe, and the
// final one carries last_char; the receiver cannot stall, so it must take
// every strobed character. After accept the value runs through the 32-step
// bcd loop, one state counts the digits, and then the N characters are sent,
// where N = max(min_width, text length) is 1 to 32; busy falls as the final
// character is put on result, and the next start can then be taken.
// min_width above 32 is saturated to 32. pad_char must be written by the user
// through cfg_we / cfg_wdata only while idle; the block does not enforce this.
// It resets to ascii '0'.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_padded_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  sida_pkg::cmd_t      cmd,
  output logic                strobe,
  output sida_pkg::res_t      result,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);

  sida_pkg::state_t              state;
  sida_pkg::state_t              state_next;

  logic [7:0]                    pad_char;
  logic                          negative;
  logic [5:0]                    width;
  logic [3:0]                    digit_count;
  logic [3:0]                    found_count;
  logic [5:0]                    index;

  logic                          accept;
  logic [sida_pkg::MagWidth-1:0] mag;
  sida_pkg::bcd_t                bcd;
  logic                          conv_done;

  logic [5:0]                    text_len;
  logic [5:0]                    total;
  logic [5:0]                    pads;
  logic [5:0]                    pos;
  logic                          last;
  logic [7:0]                    char_next;

  assign busy   = (state != sida_pkg::ST_IDLE);
  assign accept = start && !busy;

  // two's complement magnitude, also exact for the most negative value
  assign mag = cmd.value[31] ? (~cmd.value + 32'd1) : cmd.value;

  sida_dabble u_dabble (
    .clk  (clk),
    .rst  (rst),
    .load (accept),
    .mag  (mag),
    .bcd  (bcd),
    .done (conv_done)
  );

  // significant digits: highest nonzero digit, zero still prints one digit
  always_comb begin
    found_count = 4'd1;
    for (int i = 1; i < sida_pkg::BcdDigits; i++) begin
      if (bcd[i] != 4'd0) begin
        found_count = 4'(i + 1);
      end
    end
  end

  // text length, field length and pad count
  assign text_len = {2'b00, digit_count} + {5'd0, negative};
  assign total    = (text_len > width) ? text_len : width;
  assign pads     = total - text_len;
  assign pos      = total - 6'd1 - index;   // digit position from the right
  assign last     = (index == total - 6'd1);

  // character at the current emit position
  always_comb begin
    priority if (index < pads) begin
      char_next = pad_char;
    end else if (negative && (index == pads)) begin
      char_next = sida_pkg::AsciiMinus;
    end else begin
      char_next = sida_pkg::AsciiZero + {4'd0, bcd[pos[3:0]]};
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sida_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sida_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = sida_pkg::ST_CONV;
        end
      end
      sida_pkg::ST_CONV: begin
        if (conv_done) begin
          state_next = sida_pkg::ST_COUNT;
        end
      end
      sida_pkg::ST_COUNT: begin
        state_next = sida_pkg::ST_EMIT;
      end
      sida_pkg::ST_EMIT: begin
        if (last) begin
          state_next = sida_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sida_pkg::ST_IDLE;
      end
    endcase
  end

  // pad character register
  always_ff @(posedge clk) begin
    if (rst) begin
      pad_char <= sida_pkg::PadReset;
    end else if (cfg_we) begin
      pad_char <= cfg_wdata;
    end
  end

  // transaction fields, digit count and emit position
  always_ff @(posedge clk) begin
    if (accept) begin
      negative <= cmd.value[31];
      width    <= (cmd.min_width > 6'(sida_pkg::MaxWidth)) ?
                  6'(sida_pkg::MaxWidth) : cmd.min_width;
    end
    if (state == sida_pkg::ST_COUNT) begin
      digit_count <= found_count;
      index       <= 6'd0;
    end else if (state == sida_pkg::ST_EMIT) begin
      index <= index + 6'd1;
    end
  end

  // output register, one character per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (state == sida_pkg::ST_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    result.char_code <= char_next;
    result.last_char <= last;
  end

  // characters only come out of the emit phase
  a_strobe_from_emit: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state) == sida_pkg::ST_EMIT)
    else $error("strobe outside emit phase");

  // a conversion's characters are contiguous
  a_emit_contiguous: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last_char) |=> strobe)
    else $error("gap inside a character stream");

  // the final character closes the stream
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last_char) |=> !strobe)
    else $error("character after the final one");

  // the bcd unit finishes only while the sequencer waits for it
  a_done_in_conv: assert property (@(posedge clk) disable iff (rst)
    conv_done |-> state == sida_pkg::ST_CONV)
    else $error("bcd done outside conversion phase");

endmodule

// ===== rtl/sida_dabble.sv =====
// ----------------------------------------------------------------------------
// sida_dabble: iterative binary to bcd converter
// Shift-and-add-3 unit, one magnitude bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module sida_dabble (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  logic [sida_pkg::MagWidth-1:0]      mag,
  output sida_pkg::bcd_t                     bcd,
  output logic                               done
);

  logic [sida_pkg::MagWidth-1:0]    bin;
  logic [sida_pkg::StepBits-1:0]    cnt;
  logic                             run;
  sida_pkg::bcd_t                   adj;
  logic [sida_pkg::BcdDigits*4-1:0] adj_bits;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < sida_pkg::BcdDigits; i++) begin
      adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
  end

  // flat view so the shift works on bits, not on digits
  assign adj_bits = adj;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == '0);
      if (load) begin
        run <= 1'b1;
      end else if (run && (cnt == '0)) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bin <= mag;
      bcd <= '0;
      cnt <= sida_pkg::StepBits'(sida_pkg::MagWidth - 1);
    end else if (run) begin
      bcd <= {adj_bits[sida_pkg::BcdDigits*4-2:0], bin[sida_pkg::MagWidth-1]};
      bin <= {bin[sida_pkg::MagWidth-2:0], 1'b0};
      cnt <= cnt - 1'b1;
    end
  end

endmodule
